[src/fixed_size_pool_allocator_core_defines.svh]
`ifndef FIXED_SIZE_POOL_ALLOCATOR_CORE_DEFINES_SVH
`define FIXED_SIZE_POOL_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication on the core clock
`define FSPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on the core clock
`define FSPA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/fspa_pkg.sv]
package fspa_pkg;

  // default pool geometry
  localparam int SMALL_COUNT_DEF  = 8;
  localparam int MID_COUNT_DEF    = 8;
  localparam int LARGE_COUNT_DEF  = 4;
  localparam int HEADER_BYTES_DEF = 8;

  // block sizes and their log2
  localparam int SMALL_SIZE  = 16;
  localparam int MID_SIZE    = 32;
  localparam int LARGE_SIZE  = 64;
  localparam int SMALL_SHIFT = 4;
  localparam int MID_SHIFT   = 5;
  localparam int LARGE_SHIFT = 6;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_AREA_BASE = 1'b0;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_BAD_ADDR  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    POOL_SMALL = 2'd0,
    POOL_MID   = 2'd1,
    POOL_LARGE = 2'd2,
    POOL_NONE  = 2'd3
  } pool_e;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_ERROR
  } op_e;

  typedef struct packed {
    op_e     op;
    pool_e   pool;
    status_e status;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_LINK
  } back_state_e;

endpackage

[src/fspa_front.sv]
module fspa_front
  import fspa_pkg::*;
#(
  parameter int SMALL_COUNT  = SMALL_COUNT_DEF,
  parameter int MID_COUNT    = MID_COUNT_DEF,
  parameter int LARGE_COUNT  = LARGE_COUNT_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int IW           = 5
) (
  input  logic          req_type_i,
  input  logic [15:0]   request_bytes_i,
  input  logic [31:0]   payload_address_i,
  input  logic [31:0]   area_base_i,
  output cmd_t          cmd_o,
  output logic [IW-1:0] idx_o
);

  // byte offsets where each pool ends, from the area base
  localparam int END0  = SMALL_COUNT * SMALL_SIZE;
  localparam int END1  = END0 + MID_COUNT * MID_SIZE;
  localparam int END2  = END1 + LARGE_COUNT * LARGE_SIZE;
  localparam int REL_W = $clog2(END2);

  logic [31:0]      blk_off;
  logic [REL_W-1:0] rel;

  // offset of the returned block start from the area base
  assign blk_off = payload_address_i - area_base_i - 32'(HEADER_BYTES);

  // classify the item
  always_comb begin
    cmd_o = '{op: OP_ERROR, pool: POOL_NONE, status: ST_BAD_ADDR};
    idx_o = '0;
    rel   = '0;
    if (req_type_i == REQ_ALLOC) begin
      if (request_bytes_i <= 16'(SMALL_SIZE - HEADER_BYTES)) begin
        cmd_o = '{op: OP_ALLOC, pool: POOL_SMALL, status: ST_OK};
      end else if (request_bytes_i <= 16'(MID_SIZE - HEADER_BYTES)) begin
        cmd_o = '{op: OP_ALLOC, pool: POOL_MID, status: ST_OK};
      end else if (request_bytes_i <= 16'(LARGE_SIZE - HEADER_BYTES)) begin
        cmd_o = '{op: OP_ALLOC, pool: POOL_LARGE, status: ST_OK};
      end else begin
        cmd_o = '{op: OP_ERROR, pool: POOL_NONE, status: ST_TOO_LARGE};
      end
    end else begin
      if (blk_off < 32'(END0)) begin
        rel = REL_W'(blk_off);
        if (rel[SMALL_SHIFT-1:0] == '0) begin
          cmd_o = '{op: OP_FREE, pool: POOL_SMALL, status: ST_OK};
          idx_o = IW'(rel >> SMALL_SHIFT);
        end
      end else if (blk_off < 32'(END1)) begin
        rel = REL_W'(blk_off - 32'(END0));
        if (rel[MID_SHIFT-1:0] == '0) begin
          cmd_o = '{op: OP_FREE, pool: POOL_MID, status: ST_OK};
          idx_o = IW'(SMALL_COUNT) + IW'(rel >> MID_SHIFT);
        end
      end else if (blk_off < 32'(END2)) begin
        rel = REL_W'(blk_off - 32'(END1));
        if (rel[LARGE_SHIFT-1:0] == '0) begin
          cmd_o = '{op: OP_FREE, pool: POOL_LARGE, status: ST_OK};
          idx_o = IW'(SMALL_COUNT + MID_COUNT) + IW'(rel >> LARGE_SHIFT);
        end
      end
    end
  end

endmodule

[src/fspa_queue.sv]
module fspa_queue
  import fspa_pkg::*;
#(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         empty_o,
  output logic [W-1:0] data_o
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]  slot_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[src/fspa_back.sv]
module fspa_back
  import fspa_pkg::*;
#(
  parameter int SMALL_COUNT  = SMALL_COUNT_DEF,
  parameter int MID_COUNT    = MID_COUNT_DEF,
  parameter int LARGE_COUNT  = LARGE_COUNT_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int IW           = 5,
  parameter int AW           = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cmd_t          cmd_i,
  input  logic [IW-1:0] idx_i,
  input  logic          empty_i,
  output logic          pop_o,
  input  logic [31:0]   area_base_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output status_e       status_o,
  output logic [31:0]   granted_address_o,
  output pool_e         pool_class_o
);

  localparam int TOTAL     = SMALL_COUNT + MID_COUNT + LARGE_COUNT;
  localparam int FIRST_MID = SMALL_COUNT;
  localparam int FIRST_LRG = SMALL_COUNT + MID_COUNT;
  localparam int START_MID = SMALL_COUNT * SMALL_SIZE;
  localparam int START_LRG = START_MID + MID_COUNT * MID_SIZE;
  localparam logic [IW-1:0] LINK_END = IW'(TOTAL);

  // link value of an entry never written since reset
  function automatic logic [IW-1:0] reset_link(input logic [AW-1:0] i);
    logic [IW-1:0] w;
    w = IW'(i);
    if (w == IW'(SMALL_COUNT - 1) || w == IW'(FIRST_LRG - 1) || w == IW'(TOTAL - 1)) begin
      reset_link = LINK_END;
    end else begin
      reset_link = w + IW'(1);
    end
  endfunction

  back_state_e   state_q, state_d;
  logic [IW-1:0] head_q [3];
  logic [IW-1:0] hd_q, hd_d;
  pool_e         pool_q, pool_d;

  logic [IW-1:0] link_mem [TOTAL];
  logic [IW-1:0] rdata_q;
  logic [TOTAL-1:0] valid_q;

  logic          slot_free;
  logic [IW-1:0] head_sel;
  logic [IW-1:0] link_val;
  logic [IW-1:0] rel_blk;
  logic [31:0]   grant_calc;
  logic          mem_we, mem_re;
  logic [AW-1:0] waddr, raddr;
  logic [IW-1:0] wdata;
  logic          head_we;
  pool_e         head_wsel;
  logic [IW-1:0] head_wdata;
  logic          load_out;
  status_e       res_status;
  pool_e         res_pool;
  logic [31:0]   res_grant;

  logic          out_valid_q;
  status_e       out_status_q;
  pool_e         out_pool_q;
  logic [31:0]   out_grant_q;

  assign slot_free = !out_valid_q || out_ready_i;

  // head of the pool named by the queued command
  always_comb begin
    case (cmd_i.pool)
      POOL_SMALL: head_sel = head_q[0];
      POOL_MID:   head_sel = head_q[1];
      POOL_LARGE: head_sel = head_q[2];
      default:    head_sel = LINK_END;
    endcase
  end

  // link of the popped block, reset chain if never written
  assign link_val = valid_q[hd_q[AW-1:0]] ? rdata_q : reset_link(hd_q[AW-1:0]);

  // payload address of the granted block
  always_comb begin
    rel_blk    = '0;
    grant_calc = '0;
    case (pool_q)
      POOL_SMALL: begin
        rel_blk    = hd_q;
        grant_calc = area_base_i + 32'(HEADER_BYTES) + (32'(rel_blk) << SMALL_SHIFT);
      end
      POOL_MID: begin
        rel_blk    = hd_q - IW'(FIRST_MID);
        grant_calc = area_base_i + 32'(HEADER_BYTES + START_MID) +
                     (32'(rel_blk) << MID_SHIFT);
      end
      POOL_LARGE: begin
        rel_blk    = hd_q - IW'(FIRST_LRG);
        grant_calc = area_base_i + 32'(HEADER_BYTES + START_LRG) +
                     (32'(rel_blk) << LARGE_SHIFT);
      end
      default: ;
    endcase
  end

  // sequencer: pop, update lists, load result
  always_comb begin
    state_d    = state_q;
    hd_d       = hd_q;
    pool_d     = pool_q;
    pop_o      = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    waddr      = idx_i[AW-1:0];
    raddr      = head_sel[AW-1:0];
    wdata      = head_sel;
    head_we    = 1'b0;
    head_wsel  = cmd_i.pool;
    head_wdata = idx_i;
    load_out   = 1'b0;
    res_status = cmd_i.status;
    res_pool   = cmd_i.pool;
    res_grant  = '0;
    unique case (state_q)
      BK_IDLE: begin
        if (!empty_i && slot_free) begin
          pop_o = 1'b1;
          case (cmd_i.op)
            OP_ALLOC: begin
              if (head_sel == LINK_END) begin
                load_out   = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                mem_re  = 1'b1;
                hd_d    = head_sel;
                pool_d  = cmd_i.pool;
                state_d = BK_LINK;
              end
            end
            OP_FREE: begin
              mem_we     = 1'b1;
              head_we    = 1'b1;
              load_out   = 1'b1;
              res_status = ST_OK;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      BK_LINK: begin
        head_we    = 1'b1;
        head_wsel  = pool_q;
        head_wdata = link_val;
        load_out   = 1'b1;
        res_status = ST_OK;
        res_pool   = pool_q;
        res_grant  = grant_calc;
        state_d    = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // state, heads, link valid bits and result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      head_q[0]   <= '0;
      head_q[1]   <= IW'(FIRST_MID);
      head_q[2]   <= IW'(FIRST_LRG);
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (head_we) begin
        case (head_wsel)
          POOL_SMALL: head_q[0] <= head_wdata;
          POOL_MID:   head_q[1] <= head_wdata;
          POOL_LARGE: head_q[2] <= head_wdata;
          default: ;
        endcase
      end
      if (mem_we) begin
        valid_q[waddr] <= 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working block and result payload
  always_ff @(posedge clk_i) begin
    hd_q   <= hd_d;
    pool_q <= pool_d;
    if (load_out) begin
      out_status_q <= res_status;
      out_pool_q   <= res_pool;
      out_grant_q  <= res_grant;
    end
  end

  // link memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= link_mem[raddr];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign pool_class_o      = out_pool_q;
  assign granted_address_o = out_grant_q;

endmodule

[src/fixed_size_pool_allocator_core.sv]
// path: queue, then result register; a successful allocate adds the registered link read
// throughput: 1 item per cycle for frees and errors while results are taken; a granted
//   allocate holds off the next item during the registered read of the free-link memory
// reset: heads point at the first block of each pool, link valid bits clear so every
//   link reads as its pool's address-order chain, area base is 0; no clearing pass
`include "fixed_size_pool_allocator_core_defines.svh"

module fixed_size_pool_allocator_core
  import fspa_pkg::*;
#(
  parameter int SMALL_COUNT  = SMALL_COUNT_DEF,
  parameter int MID_COUNT    = MID_COUNT_DEF,
  parameter int LARGE_COUNT  = LARGE_COUNT_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  req_type_i,
  input  logic [15:0]           request_bytes_i,
  input  logic [31:0]           payload_address_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output logic [31:0]           granted_address_o,
  output logic [1:0]            pool_class_o,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int TOTAL = SMALL_COUNT + MID_COUNT + LARGE_COUNT;
  localparam int IW    = $clog2(TOTAL + 1);
  localparam int AW    = $clog2(TOTAL);
  localparam int QW    = $bits(cmd_t) + IW;

  logic [31:0]   area_base_q;
  cmd_t          f_cmd;
  logic [IW-1:0] f_idx;
  logic          q_push, q_full, q_pop, q_empty;
  logic [QW-1:0] q_data;
  cmd_t          q_cmd;
  logic [IW-1:0] q_idx;
  status_e       b_status;
  pool_e         b_pool;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_AREA_BASE) ? area_base_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_base_q <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_AREA_BASE) begin
      area_base_q <= pwdata;
    end
  end

  // request classification
  fspa_front #(
    .SMALL_COUNT  (SMALL_COUNT),
    .MID_COUNT    (MID_COUNT),
    .LARGE_COUNT  (LARGE_COUNT),
    .HEADER_BYTES (HEADER_BYTES),
    .IW           (IW)
  ) u_front (
    .req_type_i        (req_type_i),
    .request_bytes_i   (request_bytes_i),
    .payload_address_i (payload_address_i),
    .area_base_i       (area_base_q),
    .cmd_o             (f_cmd),
    .idx_o             (f_idx)
  );

  // command queue
  assign in_ready_o = !q_full;
  assign q_push     = in_valid_i && !q_full;

  fspa_queue #(
    .W (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  ({f_cmd, f_idx}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_data)
  );

  assign q_cmd = cmd_t'(q_data[QW-1:IW]);
  assign q_idx = q_data[IW-1:0];

  // list update and result
  fspa_back #(
    .SMALL_COUNT  (SMALL_COUNT),
    .MID_COUNT    (MID_COUNT),
    .LARGE_COUNT  (LARGE_COUNT),
    .HEADER_BYTES (HEADER_BYTES),
    .IW           (IW),
    .AW           (AW)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (q_cmd),
    .idx_i             (q_idx),
    .empty_i           (q_empty),
    .pop_o             (q_pop),
    .area_base_i       (area_base_q),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (b_status),
    .granted_address_o (granted_address_o),
    .pool_class_o      (b_pool)
  );

  assign status_o     = b_status;
  assign pool_class_o = b_pool;

  // checks
  `FSPA_ASSERT_IMP(a_grant_only_ok, out_valid_o && status_o != ST_OK, granted_address_o == '0, "address granted on a failed item")
  `FSPA_ASSERT_IMP(a_too_large_none, out_valid_o && status_o == ST_TOO_LARGE, pool_class_o == POOL_NONE, "oversize request names a pool")
  `FSPA_ASSERT_IMP(a_pop_slot_free, q_pop && out_valid_o, out_ready_i, "command popped while result slot is held")
  `FSPA_ASSERT_NXT(a_free_result, q_pop && q_cmd.op == OP_FREE, out_valid_o && status_o == ST_OK, "free did not report ok next cycle")

endmodule
